@@ sv/lpr_pkg.sv @@
// Shared constants and types for the longest prefix route lookup.
package lpr_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int ADDR_W          = 32;
    localparam int PORT_W          = 4;
    localparam int SLOT_W          = 4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Route data broadcast to every cell on a table write
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } lpr_wr_t;

    // Lookup token handed from cell to cell, carrying the best match so far
    typedef struct packed {
        logic              active;
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] best_mask;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] gateway;
        logic [SLOT_W-1:0] slot;
    } lpr_tok_t;

endpackage

@@ sv/lpr_cell.sv @@
// One route slot: holds its entry and updates the passing lookup token.
module lpr_cell #(
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  lpr_pkg::lpr_wr_t wr,
    input  lpr_pkg::lpr_tok_t tok_in,
    output lpr_pkg::lpr_tok_t tok_out
);

    logic                      valid_reg;
    logic [lpr_pkg::ADDR_W-1:0] prefix_reg;
    logic [lpr_pkg::ADDR_W-1:0] mask_reg;
    logic [lpr_pkg::ADDR_W-1:0] gateway_reg;
    logic [lpr_pkg::PORT_W-1:0] port_reg;

    lpr_pkg::lpr_tok_t tok_reg;
    lpr_pkg::lpr_tok_t tok_next;
    logic              match;
    logic              take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_reg  <= wr.prefix;
            mask_reg    <= wr.mask;
            gateway_reg <= wr.gateway;
            port_reg    <= wr.port;
        end
    end

    assign match = valid_reg && ((prefix_reg & mask_reg) == (tok_in.addr & mask_reg));
    // >= lets the later, higher slot win on equal masks
    assign take  = match && (!tok_in.found || (mask_reg >= tok_in.best_mask));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_mask = mask_reg;
            tok_next.port      = port_reg;
            tok_next.gateway   = gateway_reg;
            tok_next.slot      = lpr_pkg::SLOT_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ sv/longest_prefix_route_lookup_top.sv @@
// Longest prefix route lookup: top level with the chain of route cells.
//
// A beat is taken when start is high and busy is low. A write beat (kind 0)
// loads or clears one slot in that cycle and gives no result; writes to a
// slot at or above ENTRIES are dropped. A lookup beat (kind 1) sends a token
// down a chain of ENTRIES cells, one cell per cycle, each cell holding one
// route; done pulses for exactly one cycle once the token has left the last
// cell register, with hit, out_port, next_hop and matched_slot valid in that
// cycle only. The receiver cannot stall, so sample the result on done.
// busy is high while a lookup is in the chain and drops in the done cycle,
// so a new beat can be taken then; a new lookup waits until the last one has
// left the cell chain. Write beats are taken every cycle while idle.
module longest_prefix_route_lookup_top #(
    parameter int ENTRIES = lpr_pkg::ENTRIES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [lpr_pkg::SLOT_W-1:0]  slot,
    input  logic                        write_valid,
    input  logic [lpr_pkg::ADDR_W-1:0]  write_prefix,
    input  logic [lpr_pkg::ADDR_W-1:0]  write_mask,
    input  logic [lpr_pkg::ADDR_W-1:0]  write_gateway,
    input  logic [lpr_pkg::PORT_W-1:0]  write_port,
    input  logic [lpr_pkg::ADDR_W-1:0]  lookup_address,
    output logic                        done,
    output logic                        hit,
    output logic [lpr_pkg::PORT_W-1:0]  out_port,
    output logic [lpr_pkg::ADDR_W-1:0]  next_hop,
    output logic [lpr_pkg::SLOT_W-1:0]  matched_slot
);

    logic              busy_reg;
    logic              busy_next;
    logic              accept;
    logic              accept_write;
    logic              accept_lookup;
    lpr_pkg::lpr_wr_t  wr;
    lpr_pkg::lpr_tok_t tok [0:ENTRIES];
    logic [ENTRIES-1:0] tok_act;

    assign done          = tok[ENTRIES].active;
    assign busy          = busy_reg && !done;
    assign accept        = start && !busy;
    assign accept_write  = accept && (kind == lpr_pkg::KIND_WRITE);
    assign accept_lookup = accept && (kind == lpr_pkg::KIND_LOOKUP);

    always_comb
    begin
        busy_next = busy_reg;
        if (accept_lookup)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign wr.valid   = write_valid;
    assign wr.prefix  = write_prefix;
    assign wr.mask    = write_mask;
    assign wr.gateway = write_gateway;
    assign wr.port    = write_port;

    // Token enters with no match and zero payload, so a miss reads as zeros
    always_comb
    begin
        tok[0]           = '0;
        tok[0].active    = accept_lookup;
        tok[0].addr      = lookup_address;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic wr_en;

        assign wr_en = accept_write && (32'(slot) == 32'(i));

        lpr_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );

        assign tok_act[i] = tok[i+1].active;
    end

    assign hit          = tok[ENTRIES].found;
    assign out_port     = tok[ENTRIES].port;
    assign next_hop     = tok[ENTRIES].gateway;
    assign matched_slot = tok[ENTRIES].slot;

`ifndef SYNTHESIS
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_act) <= 1)
        else $error("more than one lookup token in the chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (tok_act == '0))
        else $error("token in the chain while idle");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_lookup |=> busy_reg)
        else $error("busy not raised after lookup taken");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (out_port == '0 && next_hop == '0 && matched_slot == '0))
        else $error("miss result carries non-zero payload");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the longest prefix route lookup: route table predictor and driver.
`timescale 1ns / 1ps

class route_scoreboard;

    typedef struct {
        bit        hit;
        bit [3:0]  port;
        bit [31:0] hop;
        bit [3:0]  slot;
    } route_result_t;

    bit            route_valid  [lpr_pkg::ENTRIES_DEFAULT];
    bit [31:0]     route_prefix [lpr_pkg::ENTRIES_DEFAULT];
    bit [31:0]     route_mask   [lpr_pkg::ENTRIES_DEFAULT];
    bit [31:0]     route_gw     [lpr_pkg::ENTRIES_DEFAULT];
    bit [3:0]      route_port   [lpr_pkg::ENTRIES_DEFAULT];
    route_result_t pending_routes[$];
    int            errors;

    function void report(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Accepted beat: a write updates the table, a lookup queues its best route
    function void note_beat(bit k, bit [3:0] s, bit v, bit [31:0] p, bit [31:0] m,
                            bit [31:0] g, bit [3:0] pt, bit [31:0] addr);
        route_result_t res;
        bit [31:0]     best_mask;
        if (k == lpr_pkg::KIND_WRITE) begin
            if (s < lpr_pkg::ENTRIES_DEFAULT) begin
                route_valid[s]  = v;
                route_prefix[s] = p;
                route_mask[s]   = m;
                route_gw[s]     = g;
                route_port[s]   = pt;
            end
            return;
        end
        res       = '{default: 0};
        best_mask = '0;
        for (int i = 0; i < lpr_pkg::ENTRIES_DEFAULT; i++) begin
            // >= so a later slot with an equal mask takes over
            if (route_valid[i] && ((route_prefix[i] & route_mask[i]) == (addr & route_mask[i]))
                && (!res.hit || route_mask[i] >= best_mask)) begin
                res.hit   = 1'b1;
                best_mask = route_mask[i];
                res.port  = route_port[i];
                res.hop   = route_gw[i];
                res.slot  = i[3:0];
            end
        end
        pending_routes.push_back(res);
    endfunction

    function void check_result(logic h, logic [3:0] pt, logic [31:0] hop, logic [3:0] s);
        route_result_t exp_res;
        if (pending_routes.size() == 0) begin
            report($sformatf("result with nothing pending: hit=%b port=%0d hop=%h slot=%0d",
                             h, pt, hop, s));
            return;
        end
        exp_res = pending_routes.pop_front();
        if (h !== exp_res.hit || pt !== exp_res.port || hop !== exp_res.hop
            || s !== exp_res.slot)
            report({$sformatf("exp hit=%b port=%0d hop=%h slot=%0d",
                              exp_res.hit, exp_res.port, exp_res.hop, exp_res.slot),
                    $sformatf(", got hit=%b port=%0d hop=%h slot=%0d", h, pt, hop, s)});
    endfunction

endclass

module tb;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [3:0]  slot;
    logic        write_valid;
    logic [31:0] write_prefix;
    logic [31:0] write_mask;
    logic [31:0] write_gateway;
    logic [3:0]  write_port;
    logic [31:0] lookup_address;
    logic        done;
    logic        hit;
    logic [3:0]  out_port;
    logic [31:0] next_hop;
    logic [3:0]  matched_slot;

    route_scoreboard sb;
    logic [31:0]     net_base[4];

    longest_prefix_route_lookup_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .slot           (slot),
        .write_valid    (write_valid),
        .write_prefix   (write_prefix),
        .write_mask     (write_mask),
        .write_gateway  (write_gateway),
        .write_port     (write_port),
        .lookup_address (lookup_address),
        .done           (done),
        .hit            (hit),
        .out_port       (out_port),
        .next_hop       (next_hop),
        .matched_slot   (matched_slot)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("** longest_prefix_route_lookup_top: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(hit, out_port, next_hop, matched_slot);
    end

    function automatic logic [31:0] prefix_mask(int len);
        if (len <= 0)
            return '0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    task automatic send_beat(logic k, logic [3:0] s, logic v, logic [31:0] p, logic [31:0] m,
                             logic [31:0] g, logic [3:0] pt, logic [31:0] addr);
        @(negedge clk);
        start          <= 1'b1;
        kind           <= k;
        slot           <= s;
        write_valid    <= v;
        write_prefix   <= p;
        write_mask     <= m;
        write_gateway  <= g;
        write_port     <= pt;
        lookup_address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.note_beat(k, s, v, p, m, g, pt, addr);
    endtask

    // Junk on the unused lookup field
    task automatic write_route(logic [3:0] s, logic v, logic [31:0] p, logic [31:0] m,
                               logic [31:0] g, logic [3:0] pt);
        send_beat(lpr_pkg::KIND_WRITE, s, v, p, m, g, pt, $urandom);
    endtask

    // Junk on every write field
    task automatic lookup(logic [31:0] addr);
        send_beat(lpr_pkg::KIND_LOOKUP, 4'($urandom), 1'($urandom), $urandom, $urandom,
                  $urandom, 4'($urandom), addr);
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start          <= 1'b0;
            kind           <= 1'($urandom);
            slot           <= 4'($urandom);
            write_valid    <= 1'($urandom);
            write_prefix   <= $urandom;
            write_mask     <= $urandom;
            write_gateway  <= $urandom;
            write_port     <= 4'($urandom);
            lookup_address <= $urandom;
        end
    endtask

    initial
    begin
        int          r;
        int          len;
        logic [31:0] m;
        logic [31:0] p;
        logic [31:0] a;

        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        kind           = lpr_pkg::KIND_WRITE;
        slot           = '0;
        write_valid    = 1'b0;
        write_prefix   = '0;
        write_mask     = '0;
        write_gateway  = '0;
        write_port     = '0;
        lookup_address = '0;
        for (int i = 0; i < 4; i++)
            net_base[i] = $urandom;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table misses
        lookup($urandom);
        // default route in slot 0
        write_route(4'd0, 1'b1, $urandom, 32'h0, 32'h0A00_0001, 4'd1);
        lookup($urandom);
        // host route at the extremes of every field
        write_route(4'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        // equal masks: higher slot wins
        write_route(4'd5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0005, 4'd5);
        write_route(4'd9, 1'b1, 32'h0AFF_FFFF, 32'hFF00_0000, 32'hC0A8_0009, 4'd9);
        lookup(32'h0A12_3456);
        // longer prefix in the top slot
        write_route(4'd15, 1'b1, 32'h0A12_0000, 32'hFFFF_0000, 32'hC0A8_000F, 4'd0);
        lookup(32'h0A12_3456);
        // clearing writes
        write_route(4'd15, 1'b0, 32'h0A12_0000, 32'hFFFF_FFFF, 32'h0, 4'd7);
        lookup(32'h0A12_3456);
        write_route(4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 4'd0);
        lookup(32'h1234_5678);
        lookup(32'h0000_0000);
        // zero mask in a higher slot, same mask as nothing else
        write_route(4'd12, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000, 4'd12);
        lookup(32'h8000_0000);

        for (int n = 0; n < 1200; n++)
        begin
            // stretch from 500 to 800 runs back to back
            if ((n < 500 || n >= 800) && $urandom_range(99) < 6)
                idle_cycles($urandom_range(1, 20));
            if (n == 300 || n == 950)
            begin
                // drop start first so the last beat is not taken again
                idle_cycles(1);
                while (sb.pending_routes.size() != 0)
                    @(posedge clk);
            end
            if (n % 200 == 199)
                net_base[$urandom_range(3)] = $urandom;

            r = $urandom_range(99);
            if (r < 30) begin
                case ($urandom_range(5))
                    0: len = 0;
                    1: len = 8;
                    2: len = 16;
                    3: len = 24;
                    4: len = 32;
                    default: len = $urandom_range(0, 32);
                endcase
                m = ($urandom_range(19) == 0) ? $urandom : prefix_mask(len);
                p = (net_base[$urandom_range(3)] & m) | ($urandom & ~m);
                write_route(4'($urandom), $urandom_range(9) != 0, p, m, $urandom,
                            4'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 75)
                    a = net_base[$urandom_range(3)] ^ ($urandom >> $urandom_range(0, 32));
                else if (r < 95)
                    a = $urandom;
                else
                    a = (r[0]) ? 32'hFFFF_FFFF : 32'h0;
                lookup(a);
            end
        end

        idle_cycles(1);
        while (sb.pending_routes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.pending_routes.size() != 0)
            sb.report($sformatf("%0d lookups never answered", sb.pending_routes.size()));
        if (sb.errors == 0)
            $display("** longest_prefix_route_lookup_top: PASSED **");
        else
            $display("** longest_prefix_route_lookup_top: FAILED **");
        $finish;
    end

endmodule
